FILE: src/snc_pkg.sv
// Shared types, constants and helpers for the sphere node classify and shade block.
`timescale 1ns / 1ps
`default_nettype none
package snc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int IN_COORD_W     = 12;
    localparam int CENTER_W       = 14;
    localparam int RSQ_W          = 25;
    localparam int COLOR_W        = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 25;
    localparam int QUOT_BITS      = 45;
    localparam int ROOT_BITS      = 23;
    localparam int NORM_LSB       = 16;
    localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 24'h404040;
    localparam logic [7:0] COLOR_SUB = 8'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_CENTER_Z  = 3'd2,
        CFG_RADIUS_SQ = 3'd3,
        CFG_COLOR     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_OUTSIDE = 2'd0,
        CLS_PARTIAL = 2'd1,
        CLS_INSIDE  = 2'd2
    } t_cls;

    typedef struct packed {
        logic        kind;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [11:0] coord_z;
        logic [3:0]  level;
    } t_in;

    typedef struct packed {
        logic [1:0]        overlap_class;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [5:0]        texture_index;
        logic signed [7:0] normal_x;
        logic signed [7:0] normal_y;
        logic signed [7:0] normal_z;
    } t_out;

    typedef struct packed {
        logic [1:0] overlap_class;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [5:0] texture_index;
    } t_meta;

    function automatic logic [7:0] chan_minus8(input logic [7:0] c);
        logic [7:0] res;
        res = (c >= COLOR_SUB) ? c - COLOR_SUB : 8'd0;
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: src/sphere_node_classify_and_shade_top.sv
// Top level: config registers, front, divider, root, normal scaling and output register.
// Pipeline: front, divider, root and tail register stages lie between input accept and result.
// Throughput: one item per cycle; the pipeline advances whenever the output register is
// empty or being taken, so i_stall backs up to o_stall only while a result waits.
// Reset: synchronous active low; clears valid bits and config to center 0, radius 0,
// color 0x404040. Config port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module sphere_node_classify_and_shade_top #(
    parameter int COORD_BITS = snc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  snc_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output snc_pkg::t_out                     o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [snc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [snc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import snc_pkg::*;

    localparam int DW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
    localparam int SW = 2 * DW;
    localparam int PW = DW + ROOT_BITS + 1;

    logic signed [CENTER_W-1:0] r_cx;
    logic signed [CENTER_W-1:0] r_cy;
    logic signed [CENTER_W-1:0] r_cz;
    logic [RSQ_W-1:0]           r_rsq;
    logic [COLOR_W-1:0]         r_color;

    logic w_en;

    logic                 w_f_vld;
    t_meta                w_f_meta;
    logic signed [DW-1:0] w_f_d [3];
    logic [SW-1:0]        w_f_s;

    logic                 w_dv_vld;
    t_meta                w_dv_meta;
    logic signed [DW-1:0] w_dv_d [3];
    logic [QUOT_BITS-1:0] w_dv_q;

    logic                 w_sq_vld;
    t_meta                w_sq_meta;
    logic signed [DW-1:0] w_sq_d [3];
    logic [ROOT_BITS-1:0] w_sq_root;

    logic                 r_m_vld;
    t_meta                r_m_meta;
    logic signed [PW-1:0] r_m_prod [3];

    logic signed [PW:0]   w_neg [3];
    logic                 r_out_vld;
    t_out                 r_out;

    assign w_en        = !r_out_vld || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_rsq   <= '0;
            r_color <= BASE_COLOR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:  r_cx    <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:  r_cy    <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Z:  r_cz    <= i_cfg_data[CENTER_W-1:0];
                CFG_RADIUS_SQ: r_rsq   <= i_cfg_data[RSQ_W-1:0];
                CFG_COLOR:     r_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    snc_front #(
        .CB (COORD_BITS),
        .DW (DW),
        .SW (SW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_cz    (r_cz),
        .i_rsq   (r_rsq),
        .i_color (r_color),
        .o_valid (w_f_vld),
        .o_meta  (w_f_meta),
        .o_d     (w_f_d),
        .o_s     (w_f_s)
    );

    snc_div #(
        .DW (DW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_meta  (w_f_meta),
        .i_d     (w_f_d),
        .i_s     (w_f_s),
        .o_valid (w_dv_vld),
        .o_meta  (w_dv_meta),
        .o_d     (w_dv_d),
        .o_q     (w_dv_q)
    );

    snc_sqrt #(
        .DW (DW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_vld),
        .i_meta  (w_dv_meta),
        .i_d     (w_dv_d),
        .i_q     (w_dv_q),
        .o_valid (w_sq_vld),
        .o_meta  (w_sq_meta),
        .o_d     (w_sq_d),
        .o_root  (w_sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld   <= w_sq_vld;
            r_out_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_meta <= w_sq_meta;
            for (int k = 0; k < 3; k++) begin
                r_m_prod[k] <= $signed({1'b0, w_sq_root}) * w_sq_d[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_neg[k] = -(PW+1)'(r_m_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.overlap_class <= r_m_meta.overlap_class;
            r_out.blue          <= r_m_meta.blue;
            r_out.green         <= r_m_meta.green;
            r_out.red           <= r_m_meta.red;
            r_out.texture_index <= r_m_meta.texture_index;
            r_out.normal_x      <= w_neg[0][NORM_LSB+7:NORM_LSB];
            r_out.normal_y      <= w_neg[1][NORM_LSB+7:NORM_LSB];
            r_out.normal_z      <= w_neg[2][NORM_LSB+7:NORM_LSB];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
`default_nettype wire

FILE: src/snc_front.sv
// Front pipeline: offsets, squares, sums, node classification and surface color.
`timescale 1ns / 1ps
`default_nettype none
module snc_front #(
    parameter int CB = 12,
    parameter int DW = 15,
    parameter int SW = 30
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  snc_pkg::t_in                      i_data,
    input  logic signed [snc_pkg::CENTER_W-1:0] i_cx,
    input  logic signed [snc_pkg::CENTER_W-1:0] i_cy,
    input  logic signed [snc_pkg::CENTER_W-1:0] i_cz,
    input  logic [snc_pkg::RSQ_W-1:0]         i_rsq,
    input  logic [snc_pkg::COLOR_W-1:0]       i_color,
    output logic                              o_valid,
    output snc_pkg::t_meta                    o_meta,
    output logic signed [DW-1:0]              o_d [3],
    output logic [SW-1:0]                     o_s
);
    import snc_pkg::*;

    localparam int EW   = DW + 2;
    localparam int SQW  = 2 * EW;
    localparam int SUMW = SQW + 2;
    localparam logic [DW-1:0] CMASK = {DW{1'b1}} >> (DW - CB);

    logic [IN_COORD_W-1:0]      w_coord [3];
    logic signed [CENTER_W-1:0] w_ctr [3];
    logic signed [DW-1:0]       w_e [3];
    logic signed [EW-1:0]       w_sm1;
    logic signed [EW-1:0]       w_ee [3];
    logic signed [EW-1:0]       w_n [3];
    logic signed [EW-1:0]       w_f [3];
    logic signed [EW-1:0]       w_lo [3];
    logic signed [EW-1:0]       w_a [3];

    logic                 r_s1_vld;
    logic                 r_s1_kind;
    logic [5:0]           r_s1_tex;
    logic signed [EW-1:0] r_s1_f [3];
    logic signed [EW-1:0] r_s1_a [3];
    logic signed [DW-1:0] r_s1_d [3];

    logic                   r_s2_vld;
    logic                   r_s2_kind;
    logic [5:0]             r_s2_tex;
    logic signed [SQW-1:0]  r_s2_fsq [3];
    logic signed [SQW-1:0]  r_s2_asq [3];
    logic signed [2*DW-1:0] r_s2_dsq [3];
    logic signed [DW-1:0]   r_s2_d [3];

    logic signed [SUMW-1:0] w_fsum;
    logic signed [SUMW-1:0] w_asum;
    logic signed [SUMW-1:0] w_r2;
    logic [SW-1:0]          w_s;
    t_meta                  w_meta;

    logic                 r_s3_vld;
    t_meta                r_s3_meta;
    logic signed [DW-1:0] r_s3_d [3];
    logic [SW-1:0]        r_s3_s;

    always_comb begin
        w_coord[0] = i_data.coord_x;
        w_coord[1] = i_data.coord_y;
        w_coord[2] = i_data.coord_z;
        w_ctr[0]   = i_cx;
        w_ctr[1]   = i_cy;
        w_ctr[2]   = i_cz;
        w_sm1      = (EW'(1) << i_data.level) - EW'(1);
        for (int k = 0; k < 3; k++) begin
            w_e[k]  = {{(DW-CENTER_W){w_ctr[k][CENTER_W-1]}}, w_ctr[k]}
                      - ({{(DW-IN_COORD_W){1'b0}}, w_coord[k]} & CMASK);
            w_ee[k] = EW'(w_e[k]);
            w_n[k]  = w_sm1 - w_ee[k];
            w_f[k]  = (w_ee[k] > w_n[k]) ? w_ee[k] : w_n[k];
            w_lo[k] = (w_ee[k] < 0) ? w_ee[k] : '0;
            w_a[k]  = (w_lo[k] > -w_n[k]) ? w_lo[k] : -w_n[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_kind <= i_data.kind;
            r_s1_tex  <= i_data.coord_x[5:0] ^ i_data.coord_y[5:0] ^ i_data.coord_z[5:0];
            for (int k = 0; k < 3; k++) begin
                r_s1_f[k] <= w_f[k];
                r_s1_a[k] <= w_a[k];
                r_s1_d[k] <= i_data.kind ? -w_e[k] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_kind <= r_s1_kind;
            r_s2_tex  <= r_s1_tex;
            for (int k = 0; k < 3; k++) begin
                r_s2_fsq[k] <= r_s1_f[k] * r_s1_f[k];
                r_s2_asq[k] <= r_s1_a[k] * r_s1_a[k];
                r_s2_dsq[k] <= r_s1_d[k] * r_s1_d[k];
                r_s2_d[k]   <= r_s1_d[k];
            end
        end
    end

    always_comb begin
        w_fsum = SUMW'(r_s2_fsq[0]) + SUMW'(r_s2_fsq[1]) + SUMW'(r_s2_fsq[2]);
        w_asum = SUMW'(r_s2_asq[0]) + SUMW'(r_s2_asq[1]) + SUMW'(r_s2_asq[2]);
        w_r2   = $signed(SUMW'(i_rsq));
        w_s    = SW'($unsigned(r_s2_dsq[0])) + SW'($unsigned(r_s2_dsq[1]))
                 + SW'($unsigned(r_s2_dsq[2]));
        w_meta = '0;
        if (r_s2_kind) begin
            w_meta.overlap_class = CLS_OUTSIDE;
            w_meta.red           = chan_minus8(i_color[23:16]);
            w_meta.green         = chan_minus8(i_color[15:8]);
            w_meta.blue          = chan_minus8(i_color[7:0]);
            w_meta.texture_index = r_s2_tex;
        end else if (w_fsum < w_r2) begin
            w_meta.overlap_class = CLS_INSIDE;
        end else if (w_asum >= w_r2) begin
            w_meta.overlap_class = CLS_OUTSIDE;
        end else begin
            w_meta.overlap_class = CLS_PARTIAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_meta <= w_meta;
            r_s3_s    <= w_s;
            r_s3_d    <= r_s2_d;
        end
    end

    assign o_valid = r_s3_vld;
    assign o_meta  = r_s3_meta;
    assign o_d     = r_s3_d;
    assign o_s     = r_s3_s;

endmodule
`default_nettype wire

FILE: src/snc_div.sv
// Pipelined restoring divider: one quotient bit of 2^44 / s per stage.
`timescale 1ns / 1ps
`default_nettype none
module snc_div #(
    parameter int DW = 15,
    parameter int SW = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  snc_pkg::t_meta                  i_meta,
    input  logic signed [DW-1:0]            i_d [3],
    input  logic [SW-1:0]                   i_s,
    output logic                            o_valid,
    output snc_pkg::t_meta                  o_meta,
    output logic signed [DW-1:0]            o_d [3],
    output logic [snc_pkg::QUOT_BITS-1:0]   o_q
);
    import snc_pkg::*;

    localparam int QB = QUOT_BITS;

    logic                 r_vld [QB];
    t_meta                r_meta [QB];
    logic signed [DW-1:0] r_d [QB][3];
    logic [SW-1:0]        r_s [QB];
    logic [SW:0]          r_rem [QB];
    logic [QB-1:0]        r_q [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stg
        logic                 vld_in;
        t_meta                meta_in;
        logic signed [DW-1:0] d_in [3];
        logic [SW-1:0]        s_in;
        logic [SW:0]          rem_in;
        logic [QB-1:0]        q_in;
        logic [SW:0]          sh;
        logic                 ge;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign meta_in = i_meta;
            assign d_in    = i_d;
            assign s_in    = i_s;
            assign rem_in  = '0;
            assign q_in    = '0;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign meta_in = r_meta[k-1];
            assign d_in    = r_d[k-1];
            assign s_in    = r_s[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
        end

        assign sh = {rem_in[SW-1:0], 1'(k == 0)};
        assign ge = sh >= {1'b0, s_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[k] <= meta_in;
                r_d[k]    <= d_in;
                r_s[k]    <= s_in;
                r_rem[k]  <= ge ? sh - {1'b0, s_in} : sh;
                r_q[k]    <= {q_in[QB-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_meta  = r_meta[QB-1];
    assign o_d     = r_d[QB-1];
    assign o_q     = r_q[QB-1];

endmodule
`default_nettype wire

FILE: src/snc_sqrt.sv
// Pipelined integer square root: one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module snc_sqrt #(
    parameter int DW = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  snc_pkg::t_meta                  i_meta,
    input  logic signed [DW-1:0]            i_d [3],
    input  logic [snc_pkg::QUOT_BITS-1:0]   i_q,
    output logic                            o_valid,
    output snc_pkg::t_meta                  o_meta,
    output logic signed [DW-1:0]            o_d [3],
    output logic [snc_pkg::ROOT_BITS-1:0]   o_root
);
    import snc_pkg::*;

    localparam int RB = ROOT_BITS;
    localparam int NB = 2 * RB;
    localparam int RW = RB + 3;

    logic                 r_vld [RB];
    t_meta                r_meta [RB];
    logic signed [DW-1:0] r_d [RB][3];
    logic [NB-1:0]        r_n [RB];
    logic [RW-1:0]        r_rem [RB];
    logic [RB-1:0]        r_root [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stg
        logic                 vld_in;
        t_meta                meta_in;
        logic signed [DW-1:0] d_in [3];
        logic [NB-1:0]        n_in;
        logic [RW-1:0]        rem_in;
        logic [RB-1:0]        root_in;
        logic [RW-1:0]        sh;
        logic [RW-1:0]        trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign meta_in = i_meta;
            assign d_in    = i_d;
            assign n_in    = NB'(i_q);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign meta_in = r_meta[k-1];
            assign d_in    = r_d[k-1];
            assign n_in    = r_n[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign sh    = {rem_in[RW-3:0], n_in[NB-1-2*k -: 2]};
        assign trial = RW'({root_in, 2'b01});
        assign ge    = sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[k] <= meta_in;
                r_d[k]    <= d_in;
                r_n[k]    <= n_in;
                r_rem[k]  <= ge ? sh - trial : sh;
                r_root[k] <= {root_in[RB-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[RB-1];
    assign o_meta  = r_meta[RB-1];
    assign o_d     = r_d[RB-1];
    assign o_root  = r_root[RB-1];

endmodule
`default_nettype wire
